@@ rtl/ray_box_slab_test_core_assert.svh @@
// ============================================================================
// Assertion macros for the ray/box slab test core
// Clocked on aclk, disabled while aresetn is low.
// ============================================================================
`ifndef RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH

// Same-cycle implication.
`define RBST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RBST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rbst_pkg.sv @@
// ============================================================================
// rbst_pkg
// Shared types and constants of the ray/box slab test core.
// ============================================================================
package rbst_pkg;

    localparam int DATA_W        = 32;
    localparam int NUM_AXES      = 3;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t S32_MAX = 32'sh7fff_ffff;
    localparam data_t S32_MIN = 32'sh8000_0000;

    // Ordered slab interval of one axis.
    typedef struct packed {
        data_t lo;
        data_t hi;
    } slab_t;

endpackage

@@ rtl/rbst_recip.sv @@
// ============================================================================
// rbst_recip
// Restoring divider: 2^(2F) / |d|, one quotient bit per cycle, then sign and
// saturation to the 32-bit range.
// ============================================================================
module rbst_recip import rbst_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  data_t dir_in,
    output logic  busy,
    output data_t inv
);

    localparam int QW = 2 * FRACTION_BITS + 1;
    localparam int CW = $clog2(QW + 1);
    localparam int EW = (QW > 33) ? QW : 33;

    logic [DATA_W-1:0] mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    data_t             inv_reg, inv_next;

    logic [DATA_W:0]   rem_sh;
    logic              q_bit;
    logic [EW-1:0]     quo_ext;

    always_comb begin
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        inv_next  = inv_reg;
        // the numerator has a single one, at the top quotient position
        rem_sh    = {rem_reg[DATA_W-1:0], (cnt_reg == CW'(QW))};
        q_bit     = (rem_sh >= {1'b0, mag_reg});
        quo_ext   = EW'(quo_reg);

        if (start) begin
            mag_next  = dir_in[DATA_W-1] ? (~dir_in + 32'd1) : dir_in;
            neg_next  = dir_in[DATA_W-1];
            zero_next = (dir_in == '0);
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_next = q_bit ? (rem_sh - {1'b0, mag_reg}) : rem_sh;
                quo_next = {quo_reg[QW-2:0], q_bit};
                cnt_next = cnt_reg - CW'(1);
            end else begin
                // sign and saturate the finished quotient
                busy_next = 1'b0;
                if (zero_reg) begin
                    inv_next = S32_MAX;
                end else if (neg_reg) begin
                    inv_next = (quo_ext > EW'(64'h8000_0000)) ? S32_MIN
                                                              : -quo_ext[DATA_W-1:0];
                end else begin
                    inv_next = (quo_ext > EW'(64'h7fff_ffff)) ? S32_MAX
                                                              : quo_ext[DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            inv_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            inv_reg  <= inv_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
    end

    assign busy = busy_reg;
    assign inv  = inv_reg;

endmodule

@@ rtl/rbst_lane.sv @@
// ============================================================================
// rbst_lane
// One axis of the slab test: holds origin and reciprocal, forms the two
// entry/exit distances over three register stages and orders them.
// ============================================================================
module rbst_lane import rbst_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  load,
    input  data_t origin_in,
    input  data_t dir_in,
    input  data_t box_min,
    input  data_t box_max,
    output logic  busy,
    output slab_t slab
);

    localparam int DW = DATA_W + 1;
    localparam int PW = 2 * DATA_W + 1;
    localparam logic signed [PW-1:0] LIM_HI = PW'(S32_MAX);
    localparam logic signed [PW-1:0] LIM_LO = PW'(S32_MIN);

    data_t                 origin_reg;
    data_t                 inv;
    logic signed [DW-1:0]  dlo_reg, dlo_next, dhi_reg, dhi_next;
    logic signed [PW-1:0]  plo_reg, plo_next, phi_reg, phi_next;
    slab_t                 slab_reg, slab_next;
    data_t                 t1, t2;

    function automatic data_t scale_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sh;
        sh = p >>> FRACTION_BITS;
        // truncate toward zero
        if (p[PW-1] && (p[FRACTION_BITS-1:0] != '0)) begin
            sh = sh + PW'(1);
        end
        if (sh > LIM_HI) begin
            return S32_MAX;
        end else if (sh < LIM_LO) begin
            return S32_MIN;
        end
        return sh[DATA_W-1:0];
    endfunction

    rbst_recip #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_recip (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (load),
        .dir_in (dir_in),
        .busy   (busy),
        .inv    (inv)
    );

    always_comb begin
        dlo_next = $signed({box_min[DATA_W-1], box_min})
                 - $signed({origin_reg[DATA_W-1], origin_reg});
        dhi_next = $signed({box_max[DATA_W-1], box_max})
                 - $signed({origin_reg[DATA_W-1], origin_reg});
        plo_next = dlo_reg * inv;
        phi_next = dhi_reg * inv;
        t1 = scale_sat(plo_reg);
        t2 = scale_sat(phi_reg);
        slab_next.lo = (t1 < t2) ? t1 : t2;
        slab_next.hi = (t1 < t2) ? t2 : t1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
        end else if (load) begin
            origin_reg <= origin_in;
        end
        dlo_reg  <= dlo_next;
        dhi_reg  <= dhi_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        slab_reg <= slab_next;
    end

    assign slab = slab_reg;

endmodule

@@ rtl/rbst_merge.sv @@
// ============================================================================
// rbst_merge
// Combine the lane intervals: latest entry, earliest exit, hit decision.
// ============================================================================
module rbst_merge import rbst_pkg::*; (
    input  slab_t [NUM_AXES-1:0] slabs,
    input  data_t                nearest,
    output logic                 hit
);

    data_t tmin, tmax;

    always_comb begin
        tmin = slabs[0].lo;
        tmax = slabs[0].hi;
        for (int i = 1; i < NUM_AXES; i++) begin
            if (slabs[i].lo > tmin) begin
                tmin = slabs[i].lo;
            end
            if (slabs[i].hi < tmax) begin
                tmax = slabs[i].hi;
            end
        end
        hit = (tmax >= tmin) && (tmin < nearest) && (tmax > 0);
    end

endmodule

@@ rtl/ray_box_slab_test_core.sv @@
// ============================================================================
// ray_box_slab_test_core
// Ray versus axis-aligned box slab test, signed fixed point, three axis lanes.
// ============================================================================
// Send a load-ray transfer (s_tuser = 0) with the origin, direction and the
// nearest hit so far; it produces no output transfer. Each test-box transfer
// (s_tuser = 1) carries box minimum and maximum and produces one m_tdata
// transfer whose bit 0 is the hit flag. One item is in work at a time. A box
// test passes through the difference, multiply, scale/order and merge states
// before its result is offered on the output; the merge state holds while the
// output register is still full. A ray load lasts until the bit-per-cycle
// reciprocal divider in each lane has finished; the three lanes divide in
// parallel. A waiting result sits in the output register and does not block
// acceptance of the next item. Before any load every distance is zero and
// every box misses.
// ============================================================================
`include "ray_box_slab_test_core_assert.svh"

module ray_box_slab_test_core import rbst_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, t_limit (32 bits each, from bit 0 up)
    input  logic [7*DATA_W-1:0]       s_tdata,
    // action (0 = load ray, 1 = test box)
    input  logic [0:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // box_hit, then 7 zero bits
    output logic [7:0]                m_tdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SLAB  = 3'd3;
    localparam logic [2:0] S_MRG   = 3'd4;
    localparam logic [2:0] S_RECIP = 3'd5;

    logic [2:0] state_reg, state_next;
    data_t      nearest_reg, nearest_next;
    data_t      bmin_reg [NUM_AXES];
    data_t      bmax_reg [NUM_AXES];
    logic       m_tvalid_reg, m_tvalid_next;
    logic       hit_reg, hit_next;

    logic                       accept;
    logic                       load_ray;
    logic [NUM_AXES-1:0]        busy;
    logic                       busy_any;
    slab_t [NUM_AXES-1:0]       slabs;
    logic                       hit;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_ray = accept && !s_tuser[0];
    assign busy_any = |busy;

    // One lane per axis: origin, reciprocal and slab distances.
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        rbst_lane #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load     (load_ray),
            .origin_in(s_tdata[i*DATA_W +: DATA_W]),
            .dir_in   (s_tdata[(i+3)*DATA_W +: DATA_W]),
            .box_min  (bmin_reg[i]),
            .box_max  (bmax_reg[i]),
            .busy     (busy[i]),
            .slab     (slabs[i])
        );
    end

    rbst_merge u_merge (
        .slabs  (slabs),
        .nearest(nearest_reg),
        .hit    (hit)
    );

    always_comb begin
        state_next    = state_reg;
        nearest_next  = nearest_reg;
        m_tvalid_next = m_tvalid_reg;
        hit_next      = hit_reg;

        // drop the result once the output transfer completes
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser[0]) begin
                        state_next = S_DIFF;
                    end else begin
                        nearest_next = s_tdata[6*DATA_W +: DATA_W];
                        state_next   = S_RECIP;
                    end
                end
            end
            S_DIFF:  state_next = S_MUL;
            S_MUL:   state_next = S_SLAB;
            S_SLAB:  state_next = S_MRG;
            S_MRG: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    hit_next      = hit;
                    state_next    = S_IDLE;
                end
            end
            S_RECIP: begin
                if (!busy_any) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nearest_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nearest_reg  <= nearest_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        hit_reg <= hit_next;
    end

    // Capture box bounds on a test transfer; they hold through the lane stages.
    always_ff @(posedge aclk) begin
        if (accept && s_tuser[0]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                bmin_reg[i] <= s_tdata[i*DATA_W +: DATA_W];
                bmax_reg[i] <= s_tdata[(i+3)*DATA_W +: DATA_W];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, hit_reg};

    `RBST_ASSERT_NOW(a_ready_not_dividing, s_tready, !busy_any, "ready while divider busy")
    `RBST_ASSERT_NEXT(a_load_starts_div, load_ray, busy_any, "ray load did not start divider")
    `RBST_ASSERT_NOW(a_out_from_merge, $rose(m_tvalid_reg), $past(state_reg) == S_MRG, "result outside merge")

endmodule

@@ sim/tb_ray_box_slab_test_core.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_ray_box_slab_test_core
// Self-checking bench for the ray versus axis-aligned box slab test core.
// ============================================================================
// A queue of ray loads and box tests is filled by the stimulus process and
// drained by a clocked driver onto the input stream. On every accepted
// transfer the bench updates its own copy of the stored ray (origin, exact
// reciprocal of the direction, nearest hit) or computes the expected hit flag
// of the box and queues it. A clocked monitor compares every output transfer
// against the oldest queued hit flag. The run covers a directed set of edge
// cases (zero and tiny directions, saturated products, inverted and flat
// boxes, boxes before any load), random ray runs with boxes placed along the
// ray, raw random noise, random idling on both sides, one long output stall
// and pauses until the pipeline is empty.
// ============================================================================
module tb_ray_box_slab_test_core;
    import rbst_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int ONE         = 1 << FRAC;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 60;     // longer than a ray load

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_BOX  = 1'b1
    } ray_action_t;

    typedef struct packed {
        ray_action_t action;
        logic        idle_ok;   // idling allowed while this transfer is around
        data_t [2:0] pt_a;      // origin on load, box minimum on test
        data_t [2:0] pt_b;      // direction on load, box maximum on test
        data_t       t_limit;
    } ray_item_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, t_limit (32 bits each, from bit 0 up)
    logic [7*DATA_W-1:0]  s_tdata  = '0;
    // action (0 = load ray, 1 = test box)
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // box_hit, then 7 zero bits
    logic [7:0]           m_tdata;

    ray_box_slab_test_core #(
        .FRACTION_BITS (FRAC)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    ray_item_t ray_items [$];       // transfers waiting to be driven
    logic      hit_flags_due [$];   // predicted hit flags, oldest first
    ray_item_t cur;                 // transfer currently offered
    int        items_made = 0;
    int        errors     = 0;
    logic      stim_idle  = 1'b0;   // idle mode stamped on new transfers
    logic      rx_idle_ok = 1'b0;   // idle mode the receiver follows
    int        gap_left   = 0;
    int        rx_gap     = 0;
    int        hold_left  = 0;
    int        hold_seq   = 0;      // bumped by the stimulus to request a stall
    int        hold_seen  = 0;

    // Predicted copy of the stored ray.
    data_t     ray_org [3];
    data_t     ray_inv [3];
    data_t     ray_near;

    // ------------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------------
    // Exact reciprocal 2^(2*FRAC)/d on magnitudes, truncated, then saturated;
    // a zero direction maps to the largest positive value.
    function automatic data_t recip_of(data_t d);
        logic [63:0] mag;
        logic [63:0] q;
        if (d == 0) return S32_MAX;
        mag = (d < 0) ? -longint'(d) : longint'(d);
        q   = (64'd1 << (2 * FRAC)) / mag;
        if (d < 0) begin
            if (q > 64'h8000_0000) return S32_MIN;
            return data_t'(-q);
        end
        if (q > 64'h7fff_ffff) return S32_MAX;
        return data_t'(q);
    endfunction

    // 33-bit difference times reciprocal, scaled down with truncation toward
    // zero and saturated to 32 bits.
    function automatic data_t scaled_product(longint diff, data_t inv);
        logic        neg;
        logic [63:0] ma;
        logic [63:0] mi;
        logic [63:0] p;
        neg = (diff < 0) != (inv < 0);
        ma  = (diff < 0) ? -diff : diff;
        mi  = (inv < 0) ? -longint'(inv) : longint'(inv);
        p   = (ma * mi) >> FRAC;
        if (neg) begin
            if (p > 64'h8000_0000) return S32_MIN;
            return data_t'(-p);
        end
        if (p > 64'h7fff_ffff) return S32_MAX;
        return data_t'(p);
    endfunction

    // Slab test of one box against the predicted ray.
    function automatic logic slab_hit(ray_item_t it);
        int    i;
        data_t lo_b;
        data_t hi_b;
        data_t t1;
        data_t t2;
        data_t lo;
        data_t hi;
        data_t tmin;
        data_t tmax;
        tmin = S32_MIN;
        tmax = S32_MAX;
        for (i = 0; i < 3; i++) begin
            lo_b = it.pt_a[i];
            hi_b = it.pt_b[i];
            t1   = scaled_product(longint'(lo_b) - longint'(ray_org[i]), ray_inv[i]);
            t2   = scaled_product(longint'(hi_b) - longint'(ray_org[i]), ray_inv[i]);
            lo   = (t1 < t2) ? t1 : t2;
            hi   = (t1 < t2) ? t2 : t1;
            if (i == 0 || lo > tmin) tmin = lo;
            if (i == 0 || hi < tmax) tmax = hi;
        end
        return (tmax >= tmin) && (tmin < ray_near) && (tmax > 0);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic data_t units(int n);
        return data_t'(n * ONE);
    endfunction

    task automatic add_item(ray_action_t act, data_t ax, data_t ay, data_t az,
                            data_t bx, data_t by, data_t bz, data_t tl);
        ray_item_t it;
        it.action  = act;
        it.idle_ok = stim_idle;
        it.pt_a    = {az, ay, ax};
        it.pt_b    = {bz, by, bx};
        it.t_limit = tl;
        ray_items.push_back(it);
        items_made++;
    endtask

    // One well-formed run: load a ray, then test a handful of boxes, most of
    // them placed along the ray so that hits and misses both occur.
    task automatic add_ray_run();
        int    org [3];
        int    dir [3];
        int    lo [3];
        int    hi [3];
        int    i;
        int    k;
        int    n;
        int    t_hit;
        int    half;
        int    sel;
        int    tmp;
        data_t tl;
        for (i = 0; i < 3; i++) begin
            org[i] = (int'($urandom_range(0, 200)) - 100) * ONE
                     + int'($urandom_range(0, ONE - 1));
            sel = $urandom_range(0, 9);
            if (sel == 0)
                dir[i] = 0;
            else if (sel == 1)
                dir[i] = int'($urandom_range(1, 16));
            else
                dir[i] = int'($urandom_range(ONE / 16, 4 * ONE));
            if ($urandom_range(0, 1)) dir[i] = -dir[i];
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)
            tl = data_t'($urandom);
        else if (sel == 1)
            tl = '0;
        else
            tl = units($urandom_range(10, 400));
        add_item(ACT_LOAD, org[0], org[1], org[2], dir[0], dir[1], dir[2], tl);

        n = $urandom_range(2, 8);
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) begin
                t_hit = $urandom_range(0, 80);
                for (i = 0; i < 3; i++) begin
                    half  = $urandom_range(ONE / 4, 20 * ONE);
                    lo[i] = org[i] + dir[i] * t_hit - half;
                    hi[i] = org[i] + dir[i] * t_hit + half;
                end
            end else begin
                for (i = 0; i < 3; i++) begin
                    lo[i] = (int'($urandom_range(0, 600)) - 300) * ONE;
                    hi[i] = lo[i] + int'($urandom_range(0, 50 * ONE));
                end
            end
            // flip one axis now and then to get an inverted box
            if ($urandom_range(0, 9) == 0) begin
                k     = $urandom_range(0, 2);
                tmp   = lo[k];
                lo[k] = hi[k];
                hi[k] = tmp;
            end
            add_item(ACT_BOX, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                     data_t'($urandom));
        end
    endtask

    // Random part: mostly ray runs, some raw noise, idling in stretches.
    task automatic fill_random(int upto, logic idle_allowed);
        int stretch;
        stretch = 0;
        while (items_made < upto) begin
            if (stretch <= 0) begin
                stim_idle = idle_allowed && ($urandom_range(0, 2) != 0);
                stretch   = $urandom_range(3, 8);
            end
            if ($urandom_range(0, 9) < 8)
                add_ray_run();
            else
                add_item(ray_action_t'($urandom_range(0, 1)),
                         $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            stretch--;
        end
    endtask

    // Hold the sender until every predicted flag has come back.
    task automatic wait_drained();
        @(negedge aclk);
        while (ray_items.size() != 0 || s_tvalid || hit_flags_due.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Driver: offer queued transfers, insert idle bursts, predict on accept
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            // the stored ray clears on reset
            for (int i = 0; i < 3; i++) begin
                ray_org[i] = '0;
                ray_inv[i] = '0;
            end
            ray_near = '0;
        end else begin
            // Update the predicted ray or queue the expected flag.
            if (s_tvalid && s_tready) begin
                if (cur.action == ACT_LOAD) begin
                    for (int i = 0; i < 3; i++) begin
                        ray_org[i] = cur.pt_a[i];
                        ray_inv[i] = recip_of(cur.pt_b[i]);
                    end
                    ray_near = cur.t_limit;
                end else begin
                    hit_flags_due.push_back(slab_hit(cur));
                end
            end
            // Advance only when nothing is held on the bus.
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (ray_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (ray_items[0].idle_ok && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end else begin
                    cur = ray_items.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {cur.t_limit, cur.pt_b, cur.pt_a};
                    s_tuser    <= cur.action;
                    rx_idle_ok <= cur.idle_ok;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus the requested long stall
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap    = 0;
            hold_left = 0;
        end else begin
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (rx_idle_ok && $urandom_range(0, 4) == 0) begin
                rx_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each output transfer with the oldest predicted flag
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic want;
        if (aresetn && m_tvalid && m_tready) begin
            if (hit_flags_due.size() == 0) begin
                $error("box_hit: no result expected, actual %0b", m_tdata[0]);
                errors++;
            end else begin
                want = hit_flags_due.pop_front();
                if (m_tdata[0] !== want) begin
                    $error("box_hit: expected %0b, actual %0b", want, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[7:1] !== 7'd0) begin
                    $error("pad: expected 0, actual %0h", m_tdata[7:1]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        // Directed part. A box before any load must miss.
        add_item(ACT_BOX, units(-10), units(-10), units(-10),
                 units(10), units(10), units(10), '0);
        // Unit ray along +x, none along y, -1 along z; nearest hit at 100.
        add_item(ACT_LOAD, '0, '0, '0, units(1), '0, units(-1), units(100));
        add_item(ACT_BOX, units(5), units(-1), units(-20),
                 units(10), units(1), units(-5), '0);          // plain hit
        add_item(ACT_BOX, units(5), '0, units(-20),
                 units(10), units(1), units(-5), '0);          // zero diff, zero dir
        add_item(ACT_BOX, units(-10), units(-1), units(-20),
                 units(-5), units(1), units(-5), '0);          // behind the origin
        add_item(ACT_BOX, units(200), units(-1), units(-20),
                 units(300), units(1), units(-5), '0);         // past the nearest hit
        add_item(ACT_BOX, units(7), units(-1), units(-20),
                 units(7), units(1), units(-5), '0);           // flat: tmin equals tmax
        add_item(ACT_BOX, S32_MIN, S32_MIN, S32_MIN,
                 S32_MAX, S32_MAX, S32_MAX, '0);               // widest box
        add_item(ACT_BOX, units(10), units(1), units(-5),
                 units(5), units(-1), units(-20), '0);         // inverted box
        // Extreme origins and saturating reciprocals.
        add_item(ACT_LOAD, S32_MAX, S32_MIN, '0, 32'sd1, -32'sd1, S32_MIN, S32_MAX);
        add_item(ACT_BOX, S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, '0);
        add_item(ACT_BOX, '0, '0, '0, '0, '0, '0, '0);
        add_item(ACT_BOX, S32_MIN, S32_MAX, units(-3), S32_MAX, S32_MIN, units(3), '0);
        // Smallest possible nearest hit: nothing can hit.
        add_item(ACT_LOAD, units(1), units(-2), units(3), S32_MAX, units(-1), 32'sd2,
                 S32_MIN);
        add_item(ACT_BOX, '0, units(-10), '0, units(10), units(10), units(10), '0);
        // Reciprocal exactly at the signed limits; nearest hit zero.
        add_item(ACT_LOAD, '0, '0, '0, 32'sd2, -32'sd2, 32'sd3, '0);
        add_item(ACT_BOX, '0, units(-10), '0, units(10), units(10), units(10), '0);
        // Diagonal ray, box ahead and box around the origin.
        add_item(ACT_LOAD, '0, '0, '0, units(1), units(1), units(1), units(50));
        add_item(ACT_BOX, units(1), units(1), units(1), units(2), units(2), units(2), '0);
        add_item(ACT_BOX, units(-1), units(-1), units(-1),
                 units(1), units(1), units(1), '0);

        // Release reset, then let the directed part drain.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        // First random part with idling.
        fill_random(220, 1'b1);
        wait_drained();

        // Long output stall while the sender keeps offering boxes.
        stim_idle = 1'b0;
        hold_seq++;
        add_item(ACT_LOAD, '0, '0, '0, units(1), units(1), units(1), units(100));
        repeat (20) begin
            int t0;
            t0 = $urandom_range(0, 120);
            add_item(ACT_BOX, units(t0), units(t0), units(t0),
                     units(t0 + 2), units(t0 + 2), units(t0 + 2), '0);
        end
        wait_drained();

        // Second random part, then a last stretch with no idling at all.
        fill_random(370, 1'b1);
        fill_random(450, 1'b0);
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (hit_flags_due.size() != 0) begin
            $error("box_hit: %0d results never arrived", hit_flags_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rbst_pkg.sv
rtl/rbst_recip.sv
rtl/rbst_lane.sv
rtl/rbst_merge.sv
rtl/ray_box_slab_test_core.sv
sim/tb_ray_box_slab_test_core.sv
